@@ src/tcw_pkg.sv @@
// Shared constants and encodings for the text console writer.
`default_nettype none
package tcw_pkg;

    localparam int ROW_BYTES    = 160;
    localparam int MAX_COLUMN   = 80;
    localparam int SCREEN_BYTES = 4000;
    localparam int TAB_SPACES   = 4;

    localparam int POS_W = 13;
    localparam int OFS_W = 12;
    localparam int COL_W = 7;
    localparam int CHR_W = 8;
    localparam int VAL_W = 8;
    localparam int PRT_W = 2;

    // Row number of any 13-bit position.
    localparam int ROW_W = $clog2(((2 ** POS_W) - 1) / ROW_BYTES + 1);

    // Reciprocal divide by ROW_BYTES, exact for every POS_W-bit value.
    localparam int DIV_SHIFT = 26;
    localparam int DIV_RECIP = (2 ** DIV_SHIFT) / ROW_BYTES + 1;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
    localparam int PROD_W    = POS_W + RECIP_W;

    localparam int TAB_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

    localparam logic [CHR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHR_W-1:0] CHAR_SPACE   = 8'h20;

    localparam logic [VAL_W-1:0] CRTC_CURSOR_HI = 8'h0E;
    localparam logic [VAL_W-1:0] CRTC_CURSOR_LO = 8'h0F;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic       BANK_RESET = 1'b1;

    localparam logic ACT_CHAR   = 1'b0;
    localparam logic ACT_INDENT = 1'b1;

    localparam logic KIND_MEM  = 1'b0;
    localparam logic KIND_PORT = 1'b1;

    localparam logic REG_ATTRIBUTE = 1'b0;
    localparam logic REG_PORT_BANK = 1'b1;

    // Sequencer steps
    localparam logic [2:0] S_ROW  = 3'd0;
    localparam logic [2:0] S_MOVE = 3'd1;
    localparam logic [2:0] S_CHAR = 3'd2;
    localparam logic [2:0] S_ATTR = 3'd3;
    localparam logic [2:0] S_C0   = 3'd4;
    localparam logic [2:0] S_C1   = 3'd5;
    localparam logic [2:0] S_C2   = 3'd6;
    localparam logic [2:0] S_C3   = 3'd7;

endpackage
`default_nettype wire

@@ src/text_console_writer_top.sv @@
// Text console writer: video memory and CRTC cursor write sequencer.
// A non-newline character starts at S_CHAR; an indent or a newline runs S_ROW and S_MOVE, then
// an indent goes on to S_C0 to S_C3 and a newline ends. A printable character, or each space of
// a tab, runs S_CHAR, S_ATTR and S_C0 to S_C3; an indent past the last column is dropped.
// One result leaves the output register per cycle while m_axis_tready is high.
// The next input beat is taken in the cycle that loads an item's last result or ends a newline.
// Reset: position 0, attribute 0x07, colour port pair selected, no result pending.
`default_nettype none
module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // char_code[7:0], column[14:8], zero[15]
    input  wire logic        s_axis_tuser,  // action[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // port[1:0], offset[13:2], value[21:14], zero[23:22]
    output logic             m_axis_tuser,  // kind[0]
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // Control state
    logic             busy_reg, busy_next;
    logic [2:0]       step_reg, step_next;
    logic [TAB_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       attr_reg;
    logic             bank_reg;
    logic             out_valid_reg, out_valid_next;

    // Payload
    logic             action_reg, action_next;
    logic [CHR_W-1:0] char_reg, char_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             kind_reg, kind_next;
    logic [PRT_W-1:0] port_reg, port_next;
    logic [OFS_W-1:0] ofs_reg, ofs_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic             last_reg, last_next;

    logic             in_accept;
    logic             out_free;
    logic             emits;
    logic             go;
    logic             finish;
    logic             more_chars;
    logic [POS_W-1:0] wrapped;
    logic [POS_W-1:0] div_src;
    logic [PROD_W-1:0] div_prod;
    logic [PRT_W-1:0] idx_port;
    logic [PRT_W-1:0] data_port;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign emits     = (step_reg != S_ROW) && (step_reg != S_MOVE);
    assign go        = busy_reg && (!emits || out_free);

    assign wrapped  = (pos_reg >= POS_W'(SCREEN_BYTES)) ? '0 : pos_reg;
    assign div_src  = (action_reg == ACT_INDENT) ? pos_reg : wrapped;
    assign div_prod = PROD_W'(div_src) * PROD_W'(DIV_RECIP);

    assign more_chars = (char_reg == CHAR_TAB) && (idx_reg != TAB_W'(TAB_SPACES - 1));
    assign idx_port   = {bank_reg, 1'b0};
    assign data_port  = {bank_reg, 1'b1};

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        row_next       = row_reg;
        action_next    = action_reg;
        char_next      = char_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        port_next      = port_reg;
        ofs_next       = ofs_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        finish         = 1'b0;

        if (out_free)
        begin
            out_valid_next = 1'b0;
        end

        if (go)
        begin
            if (emits)
            begin
                out_valid_next = 1'b1;
                last_next      = 1'b0;
                kind_next      = KIND_PORT;
                port_next      = idx_port;
                ofs_next       = '0;
            end
            case (step_reg)
                S_ROW:
                begin
                    row_next  = div_prod[DIV_SHIFT +: ROW_W];
                    step_next = S_MOVE;
                end
                S_MOVE:
                begin
                    if (action_reg == ACT_INDENT)
                    begin
                        pos_next  = POS_W'(row_reg) * POS_W'(ROW_BYTES)
                                  + POS_W'({col_reg, 1'b0});
                        step_next = S_C0;
                    end
                    else
                    begin
                        pos_next = (POS_W'(row_reg) + POS_W'(1)) * POS_W'(ROW_BYTES);
                        finish   = 1'b1;
                    end
                end
                S_CHAR:
                begin
                    kind_next = KIND_MEM;
                    port_next = '0;
                    ofs_next  = wrapped[OFS_W-1:0];
                    val_next  = (char_reg == CHAR_TAB) ? CHAR_SPACE : char_reg;
                    pos_next  = wrapped + POS_W'(1);
                    step_next = S_ATTR;
                end
                S_ATTR:
                begin
                    kind_next = KIND_MEM;
                    port_next = '0;
                    ofs_next  = pos_reg[OFS_W-1:0];
                    val_next  = attr_reg;
                    pos_next  = pos_reg + POS_W'(1);
                    step_next = S_C0;
                end
                S_C0:
                begin
                    val_next  = CRTC_CURSOR_HI;
                    step_next = S_C1;
                end
                S_C1:
                begin
                    port_next = data_port;
                    val_next  = VAL_W'(pos_reg[POS_W-1:9]);
                    step_next = S_C2;
                end
                S_C2:
                begin
                    val_next  = CRTC_CURSOR_LO;
                    step_next = S_C3;
                end
                S_C3:
                begin
                    port_next = data_port;
                    val_next  = pos_reg[8:1];
                    if ((action_reg == ACT_CHAR) && more_chars)
                    begin
                        idx_next  = idx_reg + TAB_W'(1);
                        step_next = S_CHAR;
                    end
                    else
                    begin
                        last_next = 1'b1;
                        finish    = 1'b1;
                    end
                end
                default:
                begin
                    step_next = S_ROW;
                end
            endcase
            if (finish)
            begin
                busy_next = 1'b0;
            end
        end

        // Take the next item; an indent past the last column does nothing.
        if (in_accept)
        begin
            action_next = s_axis_tuser;
            char_next   = s_axis_tdata[7:0];
            col_next    = s_axis_tdata[14:8];
            idx_next    = '0;
            busy_next   = !((s_axis_tuser == ACT_INDENT)
                            && (s_axis_tdata[14:8] > COL_W'(MAX_COLUMN)));
            step_next   = ((s_axis_tuser == ACT_INDENT) || (s_axis_tdata[7:0] == CHAR_NEWLINE))
                          ? S_ROW : S_CHAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= S_ROW;
            idx_reg       <= '0;
            pos_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            bank_reg      <= BANK_RESET;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ATTRIBUTE: attr_reg <= cfg_data;
                    REG_PORT_BANK: bank_reg <= cfg_data[0];
                    default:       attr_reg <= attr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        char_reg   <= char_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        kind_reg   <= kind_next;
        port_reg   <= port_next;
        ofs_reg    <= ofs_next;
        val_reg    <= val_next;
    end

    assign s_axis_tready = !busy_reg || finish;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, val_reg, ofs_reg, port_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

    // The final beat of an item is always the cursor low-byte data write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_PORT && m_axis_tdata[0]))
        else $error("last beat is not a CRTC data write");

    // Memory writes carry no port, port writes carry no offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_MEM) |-> (m_axis_tdata[1:0] == 2'b00))
        else $error("memory write with nonzero port");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_PORT) |-> (m_axis_tdata[13:2] == '0))
        else $error("port write with nonzero offset");

    // A printable character or tab starts the sequencer on its memory write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tuser == ACT_CHAR && s_axis_tdata[7:0] != CHAR_NEWLINE)
        |=> (busy_reg && step_reg == S_CHAR && idx_reg == '0))
        else $error("character accepted but sequencer not started");

endmodule
`default_nettype wire
